>>> src/swma_pkg.sv
`default_nettype none

package swma_pkg;

   // Field widths
   localparam int PRICE_W    = 24;
   localparam int VOLUME_W   = 32;
   localparam int QUO_W      = PRICE_W;
   localparam int STEP_W     = $clog2(QUO_W);
   localparam int CSR_DATA_W = 7;
   localparam int CSR_INDEX_W = 1;

   localparam int WINDOW_MAX_DEFAULT = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_MODE  = 1'd1;

   // Averaging modes
   localparam logic AVG_SIMPLE   = 1'b0;
   localparam logic AVG_WEIGHTED = 1'b1;

   typedef struct packed {
      logic [PRICE_W-1:0]  price;
      logic [VOLUME_W-1:0] volume;
      logic                first_of_series;
   } req_type;

   typedef struct packed {
      logic               average_ready;
      logic [PRICE_W-1:0] average;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_OLD,
      ST_SUB,
      ST_ADD,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic mem_rd;
      logic mul_old;
      logic sub;
      logic mul_new;
      logic add;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_skip;
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

>>> src/swma_ctrl.sv
`default_nettype none

module swma_ctrl import swma_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_MUL_OLD;
         end
         ST_MUL_OLD: begin
            cmd.mul_old = 1'b1;
            state_in    = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub     = 1'b1;
            cmd.mul_new = 1'b1;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = sts.div_skip ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/swma_dpath.sv
`default_nettype none

module swma_dpath import swma_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire req_type                req_payload,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output rsp_type                     rsp_payload,
   input  wire cmd_type                cmd,
   output sts_type                     sts
);

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int PSUM_W = PRICE_W + PTR_W;
   localparam int VSUM_W = VOLUME_W + PTR_W;
   localparam int PROD_W = PRICE_W + VOLUME_W;
   localparam int WSUM_W = PROD_W + PTR_W;
   localparam int REM_W  = WSUM_W - QUO_W;

   // sample stores
   logic [PRICE_W-1:0]  price_mem  [WINDOW_MAX];
   logic [VOLUME_W-1:0] volume_mem [WINDOW_MAX];
   logic [PRICE_W-1:0]  rd_price_ff;
   logic [VOLUME_W-1:0] rd_volume_ff;

   logic [CNT_W-1:0]    len_ff, len_in;
   logic                mode_ff, mode_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PSUM_W-1:0]   psum_ff, psum_in;
   logic [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [VSUM_W-1:0]   vsum_ff, vsum_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [VOLUME_W-1:0] volume_ff, volume_in;
   logic [PTR_W-1:0]    slot_ff, slot_in;
   logic                evict_ff, evict_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    divisor_ff, divisor_in;
   logic [QUO_W-1:0]    num_ff, num_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   rsp_type             rsp_ff, rsp_in;

   logic                clear;
   logic [CNT_W-1:0]    cfg_len;
   logic                avg_ready;
   logic                skip;
   logic [PRICE_W-1:0]  mul_a;
   logic [VOLUME_W-1:0] mul_b;
   logic [WSUM_W-1:0]   numer;
   logic [REM_W:0]      trial;
   logic [REM_W:0]      diff;

   assign avg_ready = (cnt_ff >= len_ff);
   assign skip      = !avg_ready || ((mode_ff == AVG_WEIGHTED) && (vsum_ff == '0));
   assign mul_a     = cmd.mul_old ? rd_price_ff  : price_ff;
   assign mul_b     = cmd.mul_old ? rd_volume_ff : volume_ff;
   assign trial     = {rem_ff, num_ff[QUO_W-1]};
   assign diff      = trial - {1'b0, divisor_ff};

   always_comb begin
      if (csr_wdata == '0) begin
         cfg_len = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(WINDOW_MAX)) begin
         cfg_len = CNT_W'(WINDOW_MAX);
      end else begin
         cfg_len = CNT_W'(csr_wdata);
      end
   end

   always_comb begin
      len_in       = len_ff;
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      psum_in      = psum_ff;
      wsum_in      = wsum_ff;
      vsum_in      = vsum_ff;
      price_in     = price_ff;
      volume_in    = volume_ff;
      slot_in      = slot_ff;
      evict_in     = evict_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      clear        = 1'b0;
      numer        = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               len_in = cfg_len;
               clear  = 1'b1;
            end
            CSR_AVERAGE_MODE: begin
               mode_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         price_in  = req_payload.price;
         volume_in = req_payload.volume;
         clear     = clear | req_payload.first_of_series;
         slot_in   = (req_payload.first_of_series || (CNT_W'(ptr_ff) >= len_ff)) ?
                     '0 : ptr_ff;
         evict_in  = !req_payload.first_of_series && (cnt_ff >= len_ff);
      end

      if (cmd.mul_old || cmd.mul_new) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      // drop the oldest sample from the sums
      if (cmd.sub && evict_ff) begin
         psum_in = psum_ff - PSUM_W'(rd_price_ff);
         wsum_in = wsum_ff - WSUM_W'(prod_ff);
         vsum_in = vsum_ff - VSUM_W'(rd_volume_ff);
      end

      if (cmd.add) begin
         psum_in = psum_ff + PSUM_W'(price_ff);
         wsum_in = wsum_ff + WSUM_W'(prod_ff);
         vsum_in = vsum_ff + VSUM_W'(volume_ff);
         ptr_in  = ((CNT_W'(slot_ff) + CNT_W'(1)) >= len_ff) ? '0 : slot_ff + PTR_W'(1);
         if (cnt_ff < len_ff) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (clear) begin
         psum_in = '0;
         wsum_in = '0;
         vsum_in = '0;
         ptr_in  = '0;
         cnt_in  = '0;
      end

      if (cmd.div_init) begin
         quo_in = '0;
         if (mode_ff == AVG_SIMPLE) begin
            numer      = WSUM_W'(psum_ff);
            divisor_in = REM_W'(len_ff);
         end else begin
            numer      = wsum_ff;
            divisor_in = REM_W'(vsum_ff);
         end
         // quotient fits in QUO_W bits, so the upper part starts below the divisor
         rem_in = numer[WSUM_W-1:QUO_W];
         num_in = numer[QUO_W-1:0];
      end

      if (cmd.div_step) begin
         num_in = {num_ff[QUO_W-2:0], 1'b0};
         if (!diff[REM_W]) begin
            rem_in = diff[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.average_ready = avg_ready;
         rsp_in.average       = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= CNT_W'(1);
         mode_ff      <= AVG_SIMPLE;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         psum_ff      <= '0;
         wsum_ff      <= '0;
         vsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         mode_ff      <= mode_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         psum_ff      <= psum_in;
         wsum_ff      <= wsum_in;
         vsum_ff      <= vsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff   <= price_in;
      volume_ff  <= volume_in;
      slot_ff    <= slot_in;
      evict_ff   <= evict_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_price_ff  <= price_mem[slot_ff];
         rd_volume_ff <= volume_mem[slot_ff];
      end
      if (cmd.sub) begin
         price_mem[slot_ff]  <= price_ff;
         volume_mem[slot_ff] <= volume_ff;
      end
   end

   assign sts.div_skip = skip;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

endmodule

`default_nettype wire

>>> src/sliding_window_moving_average_top.sv
`default_nettype none

// Moving average over the last L price samples, simple (price sum / L) or
// volume weighted (sum of price*volume / volume sum, zero when the volume sum
// is zero), with truncating quotients in unsigned Q16.8. L comes from the
// window_length register (zero reads as 1, values above WINDOW_MAX saturate);
// writing it clears the window, while a request with first_of_series set
// clears it before its own sample enters. Each request yields one response;
// average_ready stays low and average zero until L samples are in the window.
// A request passes from acceptance through window update, divider setup and
// output load (memory read, two passes through the shared 24x32 multiplier,
// running-sum update) and the shared restoring divider, one quotient bit per
// cycle. When no quotient is needed (window not yet full, or zero volume sum
// in weighted mode) the divider steps are skipped. The next request is
// accepted in the cycle after the response is loaded, even while that
// response still waits on rsp_ready. Sample stores are not reset; only
// entries written since the last clear ever enter the running sums.

module sliding_window_moving_average_top import swma_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // register write port
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_payload,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   // sequence one request at a time through update and divide
   swma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // window stores, running sums, multiplier, divider and output register
   swma_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

>>> bench/sliding_window_moving_average_top_tb.sv
`timescale 1ns / 100ps

module sliding_window_moving_average_top_tb;
   import swma_pkg::*;

   localparam logic [PRICE_W-1:0]  PRICE_MAX  = '1;
   localparam logic [VOLUME_W-1:0] VOLUME_MAX = '1;
   localparam int RANDOM_ITEMS   = 930;
   // Settling margin after the owed averages; covers the slowest request.
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;

   sliding_window_moving_average_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Shadow of the averaging engine: window stores, running sums and the
   // two registers, updated in request order.
   // ------------------------------------------------------------------
   logic [PRICE_W-1:0]  price_store  [WINDOW_MAX_DEFAULT];
   logic [VOLUME_W-1:0] volume_store [WINDOW_MAX_DEFAULT];
   logic [63:0]  price_total;
   logic [127:0] weighted_total;
   logic [63:0]  volume_total;
   int unsigned  next_slot;
   int unsigned  fill_count;
   logic [CSR_DATA_W-1:0] cfg_window_length;
   logic         cfg_mode;

   // Averages still owed by the block, oldest first.
   rsp_type pending_averages [$];

   int error_count;
   int requests_sent;
   int responses_checked;
   int full_window_count;
   int weighted_full_count;
   int zero_volume_count;
   int series_restarts;
   int settings_count;

   // Drop the windows, sums, pointer and count.
   function automatic void clear_window_model();
      price_total    = '0;
      weighted_total = '0;
      volume_total   = '0;
      next_slot      = 0;
      fill_count     = 0;
   endfunction

   function automatic int unsigned window_in_use();
      if (cfg_window_length == 0) return 1;
      if (cfg_window_length > WINDOW_MAX_DEFAULT) return WINDOW_MAX_DEFAULT;
      return 32'(cfg_window_length);
   endfunction

   // Advance the shadow by one sample and return the average it yields.
   function automatic rsp_type predict_average(input req_type r);
      int unsigned  len;
      int unsigned  slot;
      logic [127:0] quotient;
      rsp_type      res;
      len = window_in_use();
      if (r.first_of_series) clear_window_model();
      if (next_slot >= len) next_slot = 0;
      slot = next_slot;
      // Retire the oldest sample once the window is full.
      if (fill_count >= len) begin
         price_total    -= 64'(price_store[slot]);
         weighted_total -= 128'(price_store[slot]) * 128'(volume_store[slot]);
         volume_total   -= 64'(volume_store[slot]);
      end
      price_store[slot]  = r.price;
      volume_store[slot] = r.volume;
      price_total    += 64'(r.price);
      weighted_total += 128'(r.price) * 128'(r.volume);
      volume_total   += 64'(r.volume);
      next_slot = (slot + 1 >= len) ? 0 : slot + 1;
      if (fill_count < len) fill_count++;
      res = '0;
      res.average_ready = (fill_count >= len);
      if (res.average_ready) begin
         full_window_count++;
         if (cfg_mode == AVG_SIMPLE) begin
            quotient = 128'(price_total) / 128'(len);
         end else if (volume_total != 0) begin
            weighted_full_count++;
            quotient = weighted_total / 128'(volume_total);
         end else begin
            weighted_full_count++;
            zero_volume_count++;
            quotient = '0;
         end
         res.average = quotient[PRICE_W-1:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request side: one request per call, bursts and gaps around it.
   // ------------------------------------------------------------------
   int burst_left;

   task automatic send_request(input logic [PRICE_W-1:0] price,
                               input logic [VOLUME_W-1:0] volume,
                               input logic first_of_series);
      req_type r;
      rsp_type expected;
      r.price = price;
      r.volume = volume;
      r.first_of_series = first_of_series;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      // Hold the request until the block takes it.
      do @(posedge clock); while (req_ready !== 1'b1);
      expected = predict_average(r);
      pending_averages = {pending_averages, expected};
      requests_sent++;
      if (first_of_series) series_restarts++;
   endtask

   task automatic idle_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Burst pacing: mostly short bursts with gaps both shorter and longer than a
   // request's turnaround, now and then a long unbroken stretch.
   task automatic pace_requests();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_requests($urandom_range(1, 48));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Drain: drop valid, wait for every owed average, then let the block settle.
   task automatic wait_idle();
      idle_requests(1);
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers change only with the block idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (reg_index == CSR_WINDOW_LENGTH) begin
         cfg_window_length = value;
         clear_window_model();
      end else if (reg_index == CSR_AVERAGE_MODE) begin
         cfg_mode = value[0];
      end
      settings_count++;
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern of its own, checker on every handshake.
   // ------------------------------------------------------------------
   int stall_left  = 0;
   int stall_style = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 9) != 0);
         default: rsp_ready <= ((stall_left % 16) >= 6);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_averages.size() == 0) begin
            $display("%0t: response with no request outstanding: average_ready %0d average %06h",
                     $time, rsp_payload.average_ready, rsp_payload.average);
            error_count++;
         end else begin
            want = pending_averages.pop_front();
            responses_checked++;
            if (rsp_payload.average_ready !== want.average_ready) begin
               $display("%0t: average_ready mismatch: expected %0d, actual %0d",
                        $time, want.average_ready, rsp_payload.average_ready);
               error_count++;
            end
            if (rsp_payload.average !== want.average) begin
               $display("%0t: average mismatch: expected %06h, actual %06h",
                        $time, want.average, rsp_payload.average);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles without any handshake on either channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d averages still owed",
                  $time, quiet_cycles, pending_averages.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset leaves a one-sample window in simple mode: the average is the price.
   task automatic test_default_config();
      send_request('0, '0, 1'b0);
      send_request(PRICE_MAX, VOLUME_MAX, 1'b1);
      send_request(24'h5A5A5A, 32'hA5A5A5A5, 1'b0);
      send_request(24'hA5A5A5, 32'h5A5A5A5A, 1'b0);
   endtask

   // Zero length reads as one; anything above the store depth saturates.
   task automatic test_window_length_limits();
      write_register(CSR_WINDOW_LENGTH, 7'd0);
      send_request(24'h123456, 32'd7, 1'b0);
      send_request(PRICE_MAX, 32'd1, 1'b0);
      write_register(CSR_WINDOW_LENGTH, 7'd127);
      send_request(PRICE_MAX, VOLUME_MAX, 1'b0);
      send_request(24'h000100, 32'd3, 1'b0);
      write_register(CSR_WINDOW_LENGTH, 7'd65);
      send_request(24'h000001, 32'd0, 1'b0);
      send_request('0, VOLUME_MAX, 1'b0);
   endtask

   // Full-scale sums must divide back to full scale; a restart empties the window.
   task automatic test_simple_average();
      write_register(CSR_WINDOW_LENGTH, 7'd3);
      write_register(CSR_AVERAGE_MODE, {6'd0, AVG_SIMPLE});
      repeat (4) send_request(PRICE_MAX, VOLUME_MAX, 1'b0);
      send_request(24'h000003, 32'd9, 1'b1);
   endtask

   // Zero volume sum, full-scale weights, then a mode switch that keeps the window.
   task automatic test_weighted_average();
      write_register(CSR_WINDOW_LENGTH, 7'd2);
      write_register(CSR_AVERAGE_MODE, {6'b101010, AVG_WEIGHTED});
      send_request(PRICE_MAX, 32'd0, 1'b0);
      send_request(24'h000001, 32'd0, 1'b0);
      send_request(PRICE_MAX, VOLUME_MAX, 1'b0);
      send_request('0, VOLUME_MAX, 1'b0);
      write_register(CSR_AVERAGE_MODE, {6'b010101, AVG_SIMPLE});
      send_request(24'hFFFF00, 32'd1, 1'b0);
   endtask

   // Random phases: a register setting, then enough requests to fill and slide
   // the window. Some phases keep the window and only rewrite the mode.
   task automatic test_random_phases();
      int sent;
      int pick;
      int count;
      bit zero_heavy;
      logic [CSR_DATA_W-1:0] length_value;
      logic [PRICE_W-1:0]  price;
      logic [VOLUME_W-1:0] volume;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)       length_value = 7'($urandom_range(1, 8));
         else if (pick < 8)  length_value = 7'($urandom_range(9, 64));
         else if (pick == 8) length_value = 7'd64;
         else                length_value = $urandom_range(0, 1) ? 7'd0
                                                               : 7'($urandom_range(65, 127));
         if ($urandom_range(0, 3) != 0) write_register(CSR_WINDOW_LENGTH, length_value);
         write_register(CSR_AVERAGE_MODE, {6'($urandom), 1'($urandom_range(0, 1))});
         zero_heavy = ($urandom_range(0, 4) == 0);
         count = window_in_use() + $urandom_range(4, 40);
         repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      price = '0;
            else if (pick == 1) price = PRICE_MAX;
            else if (pick < 4)  price = 24'($urandom_range(0, 255));
            else                price = 24'($urandom);
            pick = $urandom_range(0, 9);
            if (zero_heavy)     volume = (pick < 8) ? '0 : $urandom;
            else if (pick == 0) volume = '0;
            else if (pick == 1) volume = VOLUME_MAX;
            else if (pick < 4)  volume = 32'($urandom_range(0, 15));
            else                volume = $urandom;
            send_request(price, volume, ($urandom_range(0, 49) == 0));
            pace_requests();
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_payload = '0;
      error_count = 0;
      requests_sent = 0;
      responses_checked = 0;
      full_window_count = 0;
      weighted_full_count = 0;
      zero_volume_count = 0;
      series_restarts = 0;
      settings_count = 0;
      burst_left = 0;
      cfg_window_length = 7'd1;
      cfg_mode = AVG_SIMPLE;
      clear_window_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_window_length_limits();
      test_simple_average();
      test_weighted_average();
      test_random_phases();
      wait_idle();

      $display("Checked %0d of %0d requests across %0d register writes and %0d series restarts.",
               responses_checked, requests_sent, settings_count, series_restarts);
      $display("Full windows: %0d (%0d volume weighted, %0d of those with zero volume sum).",
               full_window_count, weighted_full_count, zero_volume_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sliding_window_moving_average_top.f
src/swma_pkg.sv
src/swma_ctrl.sv
src/swma_dpath.sv
src/sliding_window_moving_average_top.sv
bench/sliding_window_moving_average_top_tb.sv
